// File: hw/rtl/thm_pkg.sv
// Package for the tachometer and hour meter: input kinds, register map,
// reset values of the settings and the result record type.
// No dependencies; every other file of the block imports it.
package thm_pkg;

  // Default width of the pulse counters.
  localparam int THM_COUNT_WIDTH = 16;

  // Kind of an input item, carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_PIN   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_POWER = 2'd2
  } thm_kind_t;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_WINDOW_TICKS  = 3'd0;
  localparam logic [2:0] REG_SECOND_TICKS  = 3'd1;
  localparam logic [2:0] REG_ERASE_AFTER   = 3'd2;
  localparam logic [2:0] REG_RPM_MULT      = 3'd3;
  localparam logic [2:0] REG_INITIAL_HOBBS = 3'd4;

  // Reset values: 500 ms windows and 1 s prescale over 20 ms ticks, 2 min erase.
  localparam logic [7:0]  RST_WINDOW_TICKS  = 8'(500 / 20);
  localparam logic [7:0]  RST_SECOND_TICKS  = 8'(1000 / 20);
  localparam logic [15:0] RST_ERASE_AFTER   = 16'(2 * 60);
  localparam logic [7:0]  RST_RPM_MULT      = 8'd1;
  localparam logic [31:0] RST_INITIAL_HOBBS = 32'd0;

  localparam logic [31:0] HOBBS_SAT = 32'hFFFF_FFFF;

  // Settings handed from the register file to the datapath.
  typedef struct packed {
    logic [7:0]  window_ticks;
    logic [7:0]  second_ticks;
    logic [15:0] erase_after_seconds;
    logic [7:0]  rpm_multiplier;
    logic        hobbs_load;
    logic [31:0] hobbs_init;
  } thm_cfg_t;

  // One result record.
  typedef struct packed {
    logic        armed;
    logic        commit_request;
    logic        erase_request;
    logic        engine_running;
    logic [31:0] hobbs_seconds;
    logic [15:0] on_seconds;
    logic [15:0] window_pulses;
    logic [23:0] rpm_value;
  } thm_res_t;

endpackage

// File: hw/rtl/thm_cfg.sv
// Configuration register file of the tachometer and hour meter, APB-style port.
// Depends on thm_pkg for the register map and reset values.
module thm_cfg
  import thm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output thm_cfg_t    cfg
);

  logic [7:0]  window_ticks_r;
  logic [7:0]  second_ticks_r;
  logic [15:0] erase_after_r;
  logic [7:0]  rpm_mult_r;
  logic [31:0] initial_hobbs_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r  <= RST_WINDOW_TICKS;
      second_ticks_r  <= RST_SECOND_TICKS;
      erase_after_r   <= RST_ERASE_AFTER;
      rpm_mult_r      <= RST_RPM_MULT;
      initial_hobbs_r <= RST_INITIAL_HOBBS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_TICKS:  window_ticks_r  <= pwdata[7:0];
        REG_SECOND_TICKS:  second_ticks_r  <= pwdata[7:0];
        REG_ERASE_AFTER:   erase_after_r   <= pwdata[15:0];
        REG_RPM_MULT:      rpm_mult_r      <= pwdata[7:0];
        REG_INITIAL_HOBBS: initial_hobbs_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_TICKS:  prdata = {24'd0, window_ticks_r};
      REG_SECOND_TICKS:  prdata = {24'd0, second_ticks_r};
      REG_ERASE_AFTER:   prdata = {16'd0, erase_after_r};
      REG_RPM_MULT:      prdata = {24'd0, rpm_mult_r};
      REG_INITIAL_HOBBS: prdata = initial_hobbs_r;
      default:           prdata = 32'd0;
    endcase
  end

  // A write of the stored total also reloads the running total.
  assign cfg.window_ticks        = window_ticks_r;
  assign cfg.second_ticks        = second_ticks_r;
  assign cfg.erase_after_seconds = erase_after_r;
  assign cfg.rpm_multiplier      = rpm_mult_r;
  assign cfg.hobbs_load          = wr_en && (reg_idx == REG_INITIAL_HOBBS);
  assign cfg.hobbs_init          = pwdata;

endmodule

// File: hw/rtl/thm_core.sv
// Counter state and single-pass update logic of the tachometer and hour meter.
// Depends on thm_pkg for the kind codes, settings and result record.
module thm_core
  import thm_pkg::*;
#(
  parameter int COUNT_WIDTH = THM_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_fire,
  input  logic [1:0] kind,
  input  logic       pin_level,
  input  thm_cfg_t   cfg,
  output thm_res_t   res
);

  localparam int PROD_W = COUNT_WIDTH + 8;

  logic                   last_level_r, last_level_nxt;
  logic [COUNT_WIDTH-1:0] pulse_count_r, pulse_count_nxt;
  logic [7:0]             window_cnt_r, window_cnt_nxt;
  logic [COUNT_WIDTH-1:0] latched_r, latched_nxt;
  logic [7:0]             second_cnt_r, second_cnt_nxt;
  logic [15:0]            engine_sec_r, engine_sec_nxt;
  logic                   erased_r, erased_nxt;
  logic [31:0]            hobbs_total_r, hobbs_total_nxt;

  logic [7:0]             window_inc;
  logic [7:0]             second_inc;
  logic                   erase_req;
  logic                   commit_req;
  logic [15:0]            add_term;
  logic [32:0]            hobbs_sum;
  logic [31:0]            hobbs_sat;
  logic [PROD_W-1:0]      product;
  logic [PROD_W+23:0]     product_ext;
  logic [COUNT_WIDTH+15:0] latched_ext;

  assign window_inc = window_cnt_r + 8'd1;
  assign second_inc = second_cnt_r + 8'd1;

  always_comb begin
    last_level_nxt  = last_level_r;
    pulse_count_nxt = pulse_count_r;
    window_cnt_nxt  = window_cnt_r;
    latched_nxt     = latched_r;
    second_cnt_nxt  = second_cnt_r;
    engine_sec_nxt  = engine_sec_r;
    erased_nxt      = erased_r;
    erase_req       = 1'b0;
    commit_req      = 1'b0;
    unique case (kind)
      KIND_PIN: begin
        if (pin_level && !last_level_r) begin
          pulse_count_nxt = pulse_count_r + COUNT_WIDTH'(1);
        end
        last_level_nxt = pin_level;
      end
      KIND_TICK: begin
        window_cnt_nxt = window_inc;
        if (window_inc >= cfg.window_ticks) begin
          window_cnt_nxt  = 8'd0;
          latched_nxt     = pulse_count_r;
          pulse_count_nxt = '0;
        end
        // The seconds prescaler runs only while the new latched pulse count is nonzero.
        if (latched_nxt != '0) begin
          second_cnt_nxt = second_inc;
          if (second_inc >= cfg.second_ticks) begin
            second_cnt_nxt = 8'd0;
            engine_sec_nxt = engine_sec_r + 16'd1;
          end
        end
        if ((engine_sec_nxt > cfg.erase_after_seconds) && !erased_r) begin
          erased_nxt = 1'b1;
          erase_req  = 1'b1;
        end
      end
      KIND_POWER: begin
        if (erased_r) begin
          engine_sec_nxt = 16'd0;
          erased_nxt     = 1'b0;
          commit_req     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // One saturating adder serves both the commit and the reported total: on a
  // commit the seconds fold in and then read as zero, so both see the same sum.
  assign add_term  = commit_req ? engine_sec_r : engine_sec_nxt;
  assign hobbs_sum = {1'b0, hobbs_total_r} + {17'd0, add_term};
  assign hobbs_sat = hobbs_sum[32] ? HOBBS_SAT : hobbs_sum[31:0];

  always_comb begin
    if (cfg.hobbs_load) begin
      hobbs_total_nxt = cfg.hobbs_init;
    end else if (item_fire && commit_req) begin
      hobbs_total_nxt = hobbs_sat;
    end else begin
      hobbs_total_nxt = hobbs_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b1;
      pulse_count_r <= '0;
      window_cnt_r  <= 8'd0;
      latched_r     <= '0;
      second_cnt_r  <= 8'd0;
      engine_sec_r  <= 16'd0;
      erased_r      <= 1'b0;
      hobbs_total_r <= RST_INITIAL_HOBBS;
    end else begin
      hobbs_total_r <= hobbs_total_nxt;
      if (item_fire) begin
        last_level_r  <= last_level_nxt;
        pulse_count_r <= pulse_count_nxt;
        window_cnt_r  <= window_cnt_nxt;
        latched_r     <= latched_nxt;
        second_cnt_r  <= second_cnt_nxt;
        engine_sec_r  <= engine_sec_nxt;
        erased_r      <= erased_nxt;
      end
    end
  end

  assign product     = PROD_W'(latched_nxt) * PROD_W'(cfg.rpm_multiplier);
  assign product_ext = {24'd0, product};
  assign latched_ext = {16'd0, latched_nxt};

  assign res.rpm_value      = product_ext[23:0];
  assign res.window_pulses  = latched_ext[15:0];
  assign res.on_seconds     = engine_sec_nxt;
  assign res.hobbs_seconds  = hobbs_sat;
  assign res.engine_running = (latched_nxt != '0);
  assign res.erase_request  = erase_req;
  assign res.commit_request = commit_req;
  assign res.armed          = erased_nxt;

endmodule

// File: hw/rtl/thm_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register, so
// the input side can take an item while a result waits. Depends on thm_pkg.
module thm_out_buf
  import thm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  thm_res_t push_data,
  output logic     space,
  output logic     out_valid,
  input  logic     out_ready,
  output thm_res_t out_data
);

  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  thm_res_t main_data_r;
  thm_res_t skid_data_r;
  logic     pop;
  logic     load_main_new;
  logic     load_main_skid;
  logic     load_skid;

  assign pop       = main_valid_r & out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // The skid register only fills when the output register holds on.
  assign load_main_new  = push && (!main_valid_r || pop);
  assign load_skid      = push && main_valid_r && !pop;
  assign load_main_skid = pop && skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (load_main_new || load_main_skid) begin
      main_valid_nxt = 1'b1;
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
    if (load_skid) begin
      skid_valid_nxt = 1'b1;
    end else if (load_main_skid) begin
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main_skid) begin
      main_data_r <= skid_data_r;
    end else if (load_main_new) begin
      main_data_r <= push_data;
    end
    if (load_skid) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// File: hw/rtl/tachometer_hour_meter_top.sv
// Top level of the tachometer and hour meter: register file, counter core and
// result buffer. Depends on thm_pkg, thm_cfg, thm_core and thm_out_buf.
//
//  Channel  | Direction | Ports                          | Carries
//  ---------+-----------+--------------------------------+---------------------------------
//  in_      | slave     | tvalid/tready/tdata/tuser      | one pin sample, tick or power loss
//  out_     | master    | tvalid/tready/tdata            | one result per input item
//  cfg_     | APB slave | psel/penable/pwrite/paddr/...  | five 32-bit-aligned settings
//
// Each input item is processed in the cycle of its transfer: the counter
// update and the rpm multiply sit between the state registers and the result
// buffer, so one item is taken every clock while in_tready is high. Its result
// goes to the output or skid register; the two-entry buffer drops in_tready
// only when both are full, on buffer state alone and not on out_tready.
// rst_n is synchronous and active low; it clears all counters, restores the
// register defaults and empties the result buffer. No clearing pass is needed.
// Writing the stored hour total reloads the running total at the same edge.
module tachometer_hour_meter_top
  import thm_pkg::*;
#(
  parameter int COUNT_WIDTH = THM_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] pin_level, [7:1] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [23:0] rpm_value, [39:24] window_pulses, [55:40] on_seconds,
  // [87:56] hobbs_seconds, [88] engine_running, [89] erase_request,
  // [90] commit_request, [91] armed, [95:92] zero
  output logic [95:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  thm_cfg_t cfg;
  thm_res_t core_res;
  thm_res_t out_res;
  logic     buf_space;
  logic     in_fire;

  assign in_tready = buf_space;
  assign in_fire   = in_tvalid & buf_space;

  thm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  thm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .kind      (in_tuser),
    .pin_level (in_tdata[0]),
    .cfg       (cfg),
    .res       (core_res)
  );

  thm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (core_res),
    .space     (buf_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Result fields packed from the lowest bit up.
  assign out_tdata = {4'd0,
                      out_res.armed,
                      out_res.commit_request,
                      out_res.erase_request,
                      out_res.engine_running,
                      out_res.hobbs_seconds,
                      out_res.on_seconds,
                      out_res.window_pulses,
                      out_res.rpm_value};

endmodule
